// ----- sv/pse_pkg.sv -----
package pse_pkg;

    // field widths
    localparam int COUNT_BITS    = 12;
    localparam int TIME_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int SPEED_BITS    = FRAC_BITS + 8;
    localparam int SCALE_BITS    = 16;
    localparam int MINP_BITS     = 12;
    localparam int GAIN_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // divider: numerator is scale*count in Q(FRAC_BITS), quotient keeps the speed range
    localparam int NUM_BITS  = SCALE_BITS + COUNT_BITS + FRAC_BITS - 8;
    localparam int QUOT_BITS = SPEED_BITS - 1;
    localparam int HI_BITS   = NUM_BITS - QUOT_BITS;
    localparam int CMP_BITS  = (HI_BITS > TIME_BITS) ? HI_BITS : TIME_BITS;

    // calibration datapath, Q24
    localparam int CAL_FRAC  = 24;
    localparam int X_BITS    = 32;
    localparam int Y_BITS    = 36;
    localparam int YS_SHIFT  = CAL_FRAC - FRAC_BITS;

    // digit-serial multiplier
    localparam int MA_BITS   = 38;
    localparam int MB_BITS   = 32;
    localparam int DIG_BITS  = 8;
    localparam int N_DIG     = MB_BITS / DIG_BITS;
    localparam int SUM_BITS  = MA_BITS + DIG_BITS + 1;
    localparam int HIGH_BITS = MA_BITS + 1;
    localparam int PROD_BITS = HIGH_BITS + MB_BITS;
    localparam int RES_BITS  = PROD_BITS - CAL_FRAC;

    typedef logic [1:0] t_mul_mode;
    localparam t_mul_mode MUL_INT = 2'd0;   // plain product
    localparam t_mul_mode MUL_Q16 = 2'd1;   // rounded, >> 16
    localparam t_mul_mode MUL_Q24 = 2'd2;   // rounded, >> 24

    typedef struct packed {
        logic      start;
        t_mul_mode mode;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MINP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN  = 2'd2;

    localparam logic [SCALE_BITS-1:0] SCALE_RST = 16'd35584;
    localparam logic [MINP_BITS-1:0]  MINP_RST  = 12'd12;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST  = 16'd13107;

    // calibration constants in Q24
    localparam logic [MA_BITS-1:0]       K_A      = 38'd19384395;
    localparam logic signed [X_BITS-1:0] K_B      = 32'sd3679243;
    localparam logic [MB_BITS-1:0]       K_C3_MAG = 32'd1678;
    localparam logic [MB_BITS-1:0]       K_C2     = 32'd117441;
    localparam logic [MA_BITS-1:0]       K_C1_MAG = 38'd2521616;
    localparam logic signed [Y_BITS-1:0] K_C0     = 36'sd24184357;

    localparam logic [QUOT_BITS-1:0] RAW_LIMIT = QUOT_BITS'(100) << FRAC_BITS;

    localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS-1){1'b1}}};
    localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS-1){1'b0}}};

endpackage

// ----- sv/pse_if.sv -----
interface pse_in_if;
    logic                            valid;
    logic                            ready;
    logic [pse_pkg::COUNT_BITS-1:0]  pulse_count;
    logic [pse_pkg::TIME_BITS-1:0]   now_ms;

    modport source (output valid, pulse_count, now_ms, input ready);
    modport sink   (input valid, pulse_count, now_ms, output ready);
endinterface

interface pse_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pse_pkg::SPEED_BITS-1:0] speed_filtered;
    logic                                  measured;
    logic                                  in_range;

    modport source (output valid, speed_filtered, measured, in_range, input ready);
    modport sink   (input valid, speed_filtered, measured, in_range, output ready);
endinterface

interface pse_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pse_pkg::CFG_IDX_BITS-1:0]  index;
    logic [pse_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pse_mul.sv -----
module pse_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pse_pkg::t_mul_req              i_req,
    input  logic [pse_pkg::MA_BITS-1:0]    i_a,
    input  logic [pse_pkg::MB_BITS-1:0]    i_b,
    output logic                           o_done,
    output logic [pse_pkg::RES_BITS-1:0]   o_res
);

    localparam int CNT_BITS = (pse_pkg::N_DIG > 1) ? $clog2(pse_pkg::N_DIG) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(pse_pkg::N_DIG - 1);

    logic                               r_busy;
    logic                               r_done;
    logic [CNT_BITS-1:0]                r_cnt;
    logic [pse_pkg::MA_BITS-1:0]        r_a;
    logic [pse_pkg::MB_BITS-1:0]        r_b;
    logic [pse_pkg::HIGH_BITS-1:0]      r_hi;
    logic [pse_pkg::MB_BITS-1:0]        r_lo;
    pse_pkg::t_mul_mode                 r_mode;

    logic [pse_pkg::DIG_BITS-1:0]                  digit;
    logic [pse_pkg::MA_BITS+pse_pkg::DIG_BITS-1:0] pp;
    logic [pse_pkg::SUM_BITS-1:0]                  rnd;
    logic [pse_pkg::SUM_BITS-1:0]                  sum;
    logic [pse_pkg::PROD_BITS-1:0]                 prod;

    assign digit = r_b[pse_pkg::DIG_BITS-1:0];
    assign pp    = {{pse_pkg::DIG_BITS{1'b0}}, r_a} * {{pse_pkg::MA_BITS{1'b0}}, digit};

    // rounding constant goes in with the lowest digit
    always_comb begin
        rnd = '0;
        if (r_cnt == '0) begin
            unique case (r_mode)
                pse_pkg::MUL_Q24: rnd = pse_pkg::SUM_BITS'(1) << (pse_pkg::CAL_FRAC - 1);
                pse_pkg::MUL_Q16: rnd = pse_pkg::SUM_BITS'(1) << (pse_pkg::GAIN_BITS - 1);
                default:          rnd = '0;
            endcase
        end
    end

    assign sum  = pse_pkg::SUM_BITS'(r_hi) + pse_pkg::SUM_BITS'(pp) + rnd;
    assign prod = {r_hi, r_lo};

    always_comb begin
        unique case (r_mode)
            pse_pkg::MUL_Q24: o_res = prod[pse_pkg::CAL_FRAC +: pse_pkg::RES_BITS];
            pse_pkg::MUL_Q16: o_res = prod[pse_pkg::GAIN_BITS +: pse_pkg::RES_BITS];
            pse_pkg::MUL_INT: o_res = prod[pse_pkg::RES_BITS-1:0];
            default:          o_res = '0;
        endcase
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low digit of b first; each step retires DIG_BITS product bits into r_lo
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_hi   <= '0;
            r_mode <= i_req.mode;
        end else if (r_busy) begin
            r_hi <= sum[pse_pkg::SUM_BITS-1:pse_pkg::DIG_BITS];
            r_lo <= {sum[pse_pkg::DIG_BITS-1:0], r_lo[pse_pkg::MB_BITS-1:pse_pkg::DIG_BITS]};
            r_b  <= r_b >> pse_pkg::DIG_BITS;
        end
    end

endmodule

// ----- sv/pse_div.sv -----
module pse_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pse_pkg::NUM_BITS-1:0]    i_num,
    input  logic [pse_pkg::TIME_BITS-1:0]   i_den,
    output pse_pkg::t_div_stat              o_stat,
    output logic [pse_pkg::QUOT_BITS-1:0]   o_quot
);

    localparam int CNT_BITS = $clog2(pse_pkg::QUOT_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(pse_pkg::QUOT_BITS - 1);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_ovf;
    logic [CNT_BITS-1:0]                r_cnt;
    logic [pse_pkg::TIME_BITS-1:0]      r_rem;
    logic [pse_pkg::TIME_BITS-1:0]      r_den;
    logic [pse_pkg::QUOT_BITS-1:0]      r_nlo;
    logic [pse_pkg::QUOT_BITS-1:0]      r_q;

    logic [pse_pkg::HI_BITS-1:0]        num_hi;
    logic                               ovf;
    logic [pse_pkg::TIME_BITS:0]        trial;
    logic                               fits;

    // quotient would not fit the speed range (also covers a zero divisor)
    assign num_hi = i_num[pse_pkg::NUM_BITS-1:pse_pkg::QUOT_BITS];
    assign ovf    = pse_pkg::CMP_BITS'(num_hi) >= pse_pkg::CMP_BITS'(i_den);

    assign trial = {r_rem, r_nlo[pse_pkg::QUOT_BITS-1]};
    assign fits  = trial >= {1'b0, r_den};

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf <= ovf;
                r_cnt <= '0;
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= pse_pkg::TIME_BITS'(num_hi);
            r_nlo <= i_num[pse_pkg::QUOT_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? pse_pkg::TIME_BITS'(trial - {1'b0, r_den})
                          : trial[pse_pkg::TIME_BITS-1:0];
            r_q   <= {r_q[pse_pkg::QUOT_BITS-2:0], fits};
            r_nlo <= r_nlo << 1;
        end
    end

endmodule

// ----- sv/pulse_speed_estimator.sv -----
// Channel  Dir  Modport  Payload
// i_in     in   sink     pulse_count, now_ms
// o_out    out  source   speed_filtered, measured, in_range
// i_cfg    in   sink     index, data (0 pulse_scale, 1 min_pulses, 2 filter_gain)
//
// A count below min_pulses gives its result without any product or divide; a measurement
// whose speed is out of range or whose elapsed time is zero stops after the first product
// and the divide; a full filter update runs eight products on the shared 8-bit-digit
// multiplier and one pass of the radix-2 divider.
// One item is in work at a time; the next is taken as soon as the result sits in the
// output register, which holds it until o_out.ready. Synchronous reset, active low.
module pulse_speed_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pse_in_if.sink      i_in,
    pse_out_if.source   o_out,
    pse_cfg_if.sink     i_cfg
);

    localparam int D_BITS  = pse_pkg::SPEED_BITS + 1;
    localparam int FS_BITS = pse_pkg::SPEED_BITS + 2;
    localparam logic [pse_pkg::Y_BITS-1:0] Y_ROUND =
        (pse_pkg::YS_SHIFT == 0) ? '0 : pse_pkg::Y_BITS'(1) << (pse_pkg::YS_SHIFT - 1);
    localparam logic [pse_pkg::Y_BITS-1:0] Y_MIN_MAG =
        pse_pkg::Y_BITS'(1) << (pse_pkg::SPEED_BITS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M0W  = 4'd1;
    localparam logic [3:0] ST_DIVW = 4'd2;
    localparam logic [3:0] ST_M1W  = 4'd3;
    localparam logic [3:0] ST_M2S  = 4'd4;
    localparam logic [3:0] ST_M2W  = 4'd5;
    localparam logic [3:0] ST_M3W  = 4'd6;
    localparam logic [3:0] ST_M4W  = 4'd7;
    localparam logic [3:0] ST_M5W  = 4'd8;
    localparam logic [3:0] ST_M6W  = 4'd9;
    localparam logic [3:0] ST_YS   = 4'd10;
    localparam logic [3:0] ST_D    = 4'd11;
    localparam logic [3:0] ST_M7S  = 4'd12;
    localparam logic [3:0] ST_M7W  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]                              r_state;
    logic [3:0]                              n_state;

    logic [pse_pkg::SCALE_BITS-1:0]          r_scale;
    logic [pse_pkg::MINP_BITS-1:0]           r_minp;
    logic [pse_pkg::GAIN_BITS-1:0]           r_gain;
    logic [pse_pkg::TIME_BITS-1:0]           r_last;
    logic signed [pse_pkg::SPEED_BITS-1:0]   r_f;

    logic [pse_pkg::TIME_BITS-1:0]           r_elapsed;
    logic signed [pse_pkg::X_BITS-1:0]       r_x;
    logic [pse_pkg::MA_BITS-1:0]             r_x2;
    logic signed [pse_pkg::Y_BITS-1:0]       r_y;
    logic [pse_pkg::Y_BITS-1:0]              r_ymag;
    logic                                    r_yneg;
    logic signed [D_BITS-1:0]                r_d;
    logic                                    r_sgn;
    logic                                    r_meas;
    logic                                    r_inr;

    logic                                    r_ovalid;
    logic signed [pse_pkg::SPEED_BITS-1:0]   r_ospeed;
    logic                                    r_omeas;
    logic                                    r_oinr;

    pse_pkg::t_mul_req                       mul_req;
    logic [pse_pkg::MA_BITS-1:0]             mul_a;
    logic [pse_pkg::MB_BITS-1:0]             mul_b;
    logic                                    mul_done;
    logic [pse_pkg::RES_BITS-1:0]            mul_res;

    logic                                    div_start;
    logic [pse_pkg::NUM_BITS-1:0]            div_num;
    pse_pkg::t_div_stat                      div_stat;
    logic [pse_pkg::QUOT_BITS-1:0]           div_quot;

    logic                                    in_acc;
    logic                                    take;
    logic                                    out_load;
    logic [pse_pkg::X_BITS-1:0]              x_mag;
    logic signed [pse_pkg::Y_BITS-1:0]       term;
    logic signed [pse_pkg::Y_BITS-1:0]       y_acc;
    logic [pse_pkg::Y_BITS-1:0]              y_abs;
    logic [pse_pkg::Y_BITS-1:0]              y_rm;
    logic signed [pse_pkg::SPEED_BITS-1:0]   ys;
    logic [D_BITS-1:0]                       d_mag;
    logic signed [FS_BITS-1:0]               step;
    logic signed [FS_BITS-1:0]               fsum;
    logic signed [pse_pkg::SPEED_BITS-1:0]   f_new;

    pse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_elapsed),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc     = i_in.valid & i_in.ready;
    assign take       = i_in.pulse_count >= r_minp;
    assign out_load   = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    assign o_out.valid          = r_ovalid;
    assign o_out.speed_filtered = r_ospeed;
    assign o_out.measured       = r_omeas;
    assign o_out.in_range       = r_oinr;

    assign div_num = pse_pkg::NUM_BITS'(mul_res) << (pse_pkg::FRAC_BITS - 8);

    // sign-magnitude helpers
    assign x_mag = r_x[pse_pkg::X_BITS-1] ? pse_pkg::X_BITS'(-r_x) : pse_pkg::X_BITS'(r_x);
    assign term  = pse_pkg::Y_BITS'(mul_res);
    assign y_acc = r_sgn ? r_y - term : r_y + term;
    assign y_abs = r_y[pse_pkg::Y_BITS-1] ? pse_pkg::Y_BITS'(-r_y) : pse_pkg::Y_BITS'(r_y);
    assign y_rm  = r_ymag >> pse_pkg::YS_SHIFT;
    assign d_mag = r_d[D_BITS-1] ? D_BITS'(-r_d) : D_BITS'(r_d);

    // round y back to the speed format and saturate
    always_comb begin
        if (!r_yneg) begin
            ys = (y_rm > pse_pkg::Y_BITS'(pse_pkg::SPEED_MAX))
               ? pse_pkg::SPEED_MAX : pse_pkg::SPEED_BITS'(y_rm);
        end else begin
            ys = (y_rm > Y_MIN_MAG) ? pse_pkg::SPEED_MIN : pse_pkg::SPEED_BITS'(-y_rm);
        end
    end

    assign step = FS_BITS'(mul_res);
    assign fsum = FS_BITS'(r_f) + (r_sgn ? -step : step);

    always_comb begin
        if (fsum > FS_BITS'(pse_pkg::SPEED_MAX)) begin
            f_new = pse_pkg::SPEED_MAX;
        end else if (fsum < FS_BITS'(pse_pkg::SPEED_MIN)) begin
            f_new = pse_pkg::SPEED_MIN;
        end else begin
            f_new = pse_pkg::SPEED_BITS'(fsum);
        end
    end

    // sequencer: issue products and the divide in order
    always_comb begin
        n_state   = r_state;
        mul_req   = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (take) begin
                        mul_req.start = 1'b1;
                        mul_req.mode  = pse_pkg::MUL_INT;
                        mul_a         = pse_pkg::MA_BITS'(r_scale);
                        mul_b         = pse_pkg::MB_BITS'(i_in.pulse_count);
                        n_state       = ST_M0W;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_M0W: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    if (div_stat.ovf || div_quot > pse_pkg::RAW_LIMIT) begin
                        n_state = ST_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.mode  = pse_pkg::MUL_Q24;
                        mul_a         = pse_pkg::K_A;
                        mul_b         = pse_pkg::MB_BITS'(div_quot) << pse_pkg::YS_SHIFT;
                        n_state       = ST_M1W;
                    end
                end
            end
            ST_M1W: begin
                if (mul_done) begin
                    n_state = ST_M2S;
                end
            end
            ST_M2S: begin
                mul_req.start = 1'b1;
                mul_req.mode  = pse_pkg::MUL_Q24;
                mul_a         = pse_pkg::MA_BITS'(x_mag);
                mul_b         = pse_pkg::MB_BITS'(x_mag);
                n_state       = ST_M2W;
            end
            ST_M2W: begin
                if (mul_done) begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = pse_pkg::MUL_Q24;
                    mul_a         = mul_res[pse_pkg::MA_BITS-1:0];
                    mul_b         = pse_pkg::K_C3_MAG;
                    n_state       = ST_M3W;
                end
            end
            ST_M3W: begin
                if (mul_done) begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = pse_pkg::MUL_Q24;
                    mul_a         = mul_res[pse_pkg::MA_BITS-1:0];
                    mul_b         = pse_pkg::MB_BITS'(x_mag);
                    n_state       = ST_M4W;
                end
            end
            ST_M4W: begin
                if (mul_done) begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = pse_pkg::MUL_Q24;
                    mul_a         = r_x2;
                    mul_b         = pse_pkg::K_C2;
                    n_state       = ST_M5W;
                end
            end
            ST_M5W: begin
                if (mul_done) begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = pse_pkg::MUL_Q24;
                    mul_a         = pse_pkg::K_C1_MAG;
                    mul_b         = pse_pkg::MB_BITS'(x_mag);
                    n_state       = ST_M6W;
                end
            end
            ST_M6W: begin
                if (mul_done) begin
                    n_state = ST_YS;
                end
            end
            ST_YS: begin
                n_state = ST_D;
            end
            ST_D: begin
                n_state = ST_M7S;
            end
            ST_M7S: begin
                mul_req.start = 1'b1;
                mul_req.mode  = pse_pkg::MUL_Q16;
                mul_a         = pse_pkg::MA_BITS'(d_mag);
                mul_b         = pse_pkg::MB_BITS'(r_gain);
                n_state       = ST_M7W;
            end
            ST_M7W: begin
                if (mul_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_scale  <= pse_pkg::SCALE_RST;
            r_minp   <= pse_pkg::MINP_RST;
            r_gain   <= pse_pkg::GAIN_RST;
            r_last   <= '0;
            r_f      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    pse_pkg::CFG_SCALE: r_scale <= i_cfg.data;
                    pse_pkg::CFG_MINP:  r_minp  <= i_cfg.data[pse_pkg::MINP_BITS-1:0];
                    pse_pkg::CFG_GAIN:  r_gain  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && in_acc) begin
                if (take) begin
                    r_last <= i_in.now_ms;
                end else begin
                    r_f <= '0;
                end
            end
            if (r_state == ST_M7W && mul_done) begin
                r_f <= f_new;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_meas    <= take;
                    r_inr     <= 1'b0;
                    r_elapsed <= i_in.now_ms - r_last;
                end
            end
            ST_M1W: begin
                if (mul_done) begin
                    r_x <= $signed(mul_res[pse_pkg::X_BITS-1:0]) - pse_pkg::K_B;
                end
            end
            ST_M2S: begin
                r_y <= pse_pkg::Y_BITS'(r_x) + pse_pkg::K_C0;
            end
            ST_M2W: begin
                if (mul_done) begin
                    r_x2 <= mul_res[pse_pkg::MA_BITS-1:0];
                end
            end
            ST_M3W: begin
                // C3 is negative: the cubic term flips the sign of x
                if (mul_done) begin
                    r_sgn <= ~r_x[pse_pkg::X_BITS-1];
                end
            end
            ST_M4W: begin
                if (mul_done) begin
                    r_y   <= y_acc;
                    r_sgn <= 1'b0;
                end
            end
            ST_M5W: begin
                // C1 is negative as well
                if (mul_done) begin
                    r_y   <= y_acc;
                    r_sgn <= ~r_x[pse_pkg::X_BITS-1];
                end
            end
            ST_M6W: begin
                if (mul_done) begin
                    r_y <= y_acc;
                end
            end
            ST_YS: begin
                r_ymag <= y_abs + Y_ROUND;
                r_yneg <= r_y[pse_pkg::Y_BITS-1];
            end
            ST_D: begin
                r_d <= D_BITS'(ys) - D_BITS'(r_f);
            end
            ST_M7S: begin
                r_sgn <= r_d[D_BITS-1];
            end
            ST_M7W: begin
                if (mul_done) begin
                    r_inr <= 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_ospeed <= r_f;
            r_omeas  <= r_meas;
            r_oinr   <= r_inr;
        end
    end

endmodule

// ----- tb/pulse_speed_estimator_checker.sv -----
module pulse_speed_estimator_checker
    import pse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pse_in_if    in_ch,
    pse_out_if   out_ch,
    pse_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed;
        logic                         measured;
        logic                         in_range;
    } speed_result_t;

    // calibration polynomial coefficients, Q24
    localparam longint CAL_A  = 19384395;
    localparam longint CAL_B  = 3679243;
    localparam longint CAL_C3 = -1678;
    localparam longint CAL_C2 = 117441;
    localparam longint CAL_C1 = -2521616;
    localparam longint CAL_C0 = 24184357;

    localparam longint SPD_HI   = (longint'(1) <<< (SPEED_BITS - 1)) - 1;
    localparam longint SPD_LO   = -SPD_HI - 1;
    localparam u64_t   RAW_CEIL = u64_t'(100) << FRAC_BITS;

    logic [SCALE_BITS-1:0] scale_q;
    logic [MINP_BITS-1:0]  minp_q;
    logic [GAIN_BITS-1:0]  gain_q;
    logic [TIME_BITS-1:0]  stamp_q;
    longint                filt_q;
    speed_result_t         speed_q[$];
    int                    fails = 0;

    // round to nearest, ties away from zero
    function automatic longint round_away(longint v, int sh);
        bit   neg;
        u64_t mag;
        neg = (v < 0);
        if (neg) mag = -v;
        else mag = v;
        if (sh == 0) return v;
        mag = (mag + (u64_t'(1) << (sh - 1))) >> sh;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint mul_cal(longint a, longint b);
        bit   neg;
        u64_t ma;
        u64_t mb;
        u64_t p;
        neg = (a < 0) != (b < 0);
        if (a < 0) ma = -a;
        else ma = a;
        if (b < 0) mb = -b;
        else mb = b;
        p = (ma * mb + (u64_t'(1) << (CAL_FRAC - 1))) >> CAL_FRAC;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp_speed(longint v);
        if (v > SPD_HI) return SPD_HI;
        if (v < SPD_LO) return SPD_LO;
        return v;
    endfunction

    // advance the speed state by one measurement and return its result
    function automatic speed_result_t predict_speed(logic [COUNT_BITS-1:0] count,
                                                    logic [TIME_BITS-1:0] now);
        speed_result_t        res;
        logic [TIME_BITS-1:0] elapsed;
        u64_t                 num;
        u64_t                 raw;
        longint               x;
        longint               x2;
        longint               y;
        longint               ys;
        longint               d;
        res.measured = 1'b0;
        res.in_range = 1'b0;
        if (count >= minp_q) begin
            elapsed = now - stamp_q;
            res.measured = 1'b1;
            if (elapsed != 0) begin
                num = (u64_t'(scale_q) * u64_t'(count)) << (FRAC_BITS - 8);
                raw = num / u64_t'(elapsed);
                if (raw > u64_t'(SPD_HI)) raw = u64_t'(SPD_HI);
                if (raw <= RAW_CEIL) begin
                    x  = mul_cal(CAL_A, longint'(raw << (CAL_FRAC - FRAC_BITS))) - CAL_B;
                    x2 = mul_cal(x, x);
                    y  = x + mul_cal(mul_cal(CAL_C3, x2), x) + mul_cal(CAL_C2, x2)
                       + mul_cal(CAL_C1, x) + CAL_C0;
                    ys = clamp_speed(round_away(y, CAL_FRAC - FRAC_BITS));
                    d  = ys - filt_q;
                    filt_q = clamp_speed(filt_q + round_away(d * longint'(gain_q), 16));
                    res.in_range = 1'b1;
                end
            end
            stamp_q = now;
        end else begin
            filt_q = 0;
        end
        res.speed = SPEED_BITS'(filt_q);
        return res;
    endfunction

    task automatic report_fault(string what, longint got, longint want);
        $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        speed_result_t want;
        if (!i_rst_n) begin
            scale_q = SCALE_RST;
            minp_q  = MINP_RST;
            gain_q  = GAIN_RST;
            stamp_q = '0;
            filt_q  = 0;
            speed_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_SCALE: scale_q = cfg_ch.data[SCALE_BITS-1:0];
                    CFG_MINP:  minp_q  = cfg_ch.data[MINP_BITS-1:0];
                    CFG_GAIN:  gain_q  = cfg_ch.data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (speed_q.size() == 0) begin
                    report_fault("result with no item outstanding", out_ch.speed_filtered, 0);
                end else begin
                    want = speed_q.pop_front();
                    if (out_ch.speed_filtered !== want.speed)
                        report_fault("speed_filtered", out_ch.speed_filtered, want.speed);
                    if (out_ch.measured !== want.measured)
                        report_fault("measured", out_ch.measured, want.measured);
                    if (out_ch.in_range !== want.in_range)
                        report_fault("in_range", out_ch.in_range, want.in_range);
                end
            end
            if (in_ch.valid && in_ch.ready)
                speed_q.push_back(predict_speed(in_ch.pulse_count, in_ch.now_ms));
        end
        o_fail_count <= fails;
        o_pending    <= speed_q.size();
    end

endmodule

// ----- tb/pulse_speed_estimator_tb.sv -----
module pulse_speed_estimator_tb;
    import pse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE   = 2'd3;
    localparam int                      STALL_LIMIT = 5000;
    localparam int                      HOLD_CYCLES = 300;
    localparam int                      PHASE_ITEMS = 300;

    logic clk;
    logic rst_n;

    pse_in_if  in_ch();
    pse_out_if out_ch();
    pse_cfg_if cfg_ch();

    int fail_count;
    int pending;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;

    logic [SCALE_BITS-1:0] cur_scale;
    logic [MINP_BITS-1:0]  cur_minp;
    logic [TIME_BITS-1:0]  last_stamp;

    pulse_speed_estimator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pulse_speed_estimator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_measurement(logic [COUNT_BITS-1:0] count,
                                    logic [TIME_BITS-1:0] now);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.pulse_count = count;
        in_ch.now_ms      = now;
        do @(posedge clk); while (!in_ch.ready);
        if (count >= cur_minp) last_stamp = now;
    endtask

    // drop valid and hold until every result is back
    task automatic wait_drained;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SCALE: cur_scale = value[SCALE_BITS-1:0];
            CFG_MINP:  cur_minp  = value[MINP_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_regs(logic [CFG_DATA_BITS-1:0] scale,
                            logic [CFG_DATA_BITS-1:0] minp,
                            logic [CFG_DATA_BITS-1:0] gain);
        wait_drained();
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_MINP, minp);
        write_reg(CFG_GAIN, gain);
    endtask

    // mostly in-range measurements; some zero, short, huge gaps and low counts
    task automatic send_random;
        int                    k;
        int unsigned           min_el;
        logic [COUNT_BITS-1:0] count;
        logic [TIME_BITS-1:0]  gap;
        k = int'($urandom_range(99));
        if (k < 12 && cur_minp != 0) begin
            count = COUNT_BITS'($urandom_range(cur_minp - 1, 0));
            gap   = $urandom;
        end else begin
            if (k % 6 == 0) count = {COUNT_BITS{1'b1}};
            else count = COUNT_BITS'($urandom_range({COUNT_BITS{1'b1}}, cur_minp));
            min_el = (32'(cur_scale) * 32'(count)) / 25600 + 1;
            if (k < 20) gap = '0;
            else if (k < 30) gap = $urandom_range(min_el, 1);
            else if (k < 35) gap = $urandom;
            else gap = min_el + $urandom_range(4 * min_el + 64, 0);
        end
        send_measurement(count, last_stamp + gap);
    endtask

    initial begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.pulse_count = '0;
        in_ch.now_ms      = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_SCALE;
        cfg_ch.data       = '0;
        hold_req          = 1'b0;
        tx_idle_pct       = 27;
        rx_idle_pct       = 58;
        cur_scale         = SCALE_RST;
        cur_minp          = MINP_RST;
        last_stamp        = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings first
        send_measurement(12'd0, 32'd0);             // below threshold
        send_measurement(12'd12, 32'd0);            // zero elapsed
        send_measurement(12'd4095, 32'd1);          // raw speed saturates
        send_measurement(12'd12, 32'd18);
        send_measurement(12'd20, 32'd1018);
        send_measurement(12'd11, 32'd2000);         // clears the filter
        send_measurement(12'd4095, 32'hFFFF_FFF0);
        send_measurement(12'd50, 32'h0000_0100);    // timestamp wrap
        send_measurement(12'd13, 32'h0000_0100);

        // unit scale: raw speed exactly at the limit, then one step past it
        set_regs(16'd256, 16'd12, 16'hFFFF);
        send_measurement(12'd100, 32'h0000_0101);
        send_measurement(12'd101, 32'h0000_0102);

        // zero threshold, zero scale, zero gain
        set_regs(16'd0, 16'd0, 16'd0);
        send_measurement(12'd0, 32'h0000_0200);
        send_measurement(12'd0, 32'h0000_0200);
        send_measurement(12'd4095, 32'h8000_0000);

        // top threshold with stray upper data bits, full scale
        set_regs(16'hFFFF, 16'hAFFF, 16'h8000);
        send_measurement(12'd4094, 32'h8000_0100);
        send_measurement(12'd4095, 32'h7FFF_FFFF);
        send_measurement(12'd4095, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_SPARE, 16'h5A5A);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_regs(SCALE_RST, CFG_DATA_BITS'(MINP_RST), GAIN_RST);
                1: set_regs(16'hFFFF, 16'd4095, 16'hFFFF);
                2: set_regs(16'd0, 16'd1, 16'd0);
                3: set_regs(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom_range(300, 1)),
                            CFG_DATA_BITS'($urandom));
                4: set_regs(16'd1, 16'd0, 16'd1);
                default: set_regs(CFG_DATA_BITS'($urandom),
                                  CFG_DATA_BITS'($urandom_range(4095, 0)),
                                  CFG_DATA_BITS'($urandom));
            endcase
            if (phase < 2) begin
                tx_idle_pct = 27;
                rx_idle_pct = 58;
            end else if (phase < 4) begin
                tx_idle_pct = 58;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold results back while items keep coming
                if (n == 100 && (phase == 0 || phase == 4)) hold_req = 1'b1;
                // pause the sender until every result is in
                if (n == 200 && phase == 5) wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
